// ----- rtl/lru_set_assoc_cache_sim_macros.svh -----
// Assertion helpers shared by the cache simulator RTL.
`ifndef LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH
`define LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

// ----- rtl/lsc_pkg.sv -----
package lsc_pkg;

  // Fixed field widths.
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 62;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int BB_W       = 6;
  localparam int TAG_SH_W   = 7;
  localparam int CNT_W      = 32;

  // Access kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_MODIFY = 2'd2,
    REQ_IFETCH = 2'd3
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS_USED  = 2'd2
  } cfg_idx_e;

  // Outcome of one lookup.
  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
  } outcome_t;

endpackage

// ----- rtl/lsc_repl.sv -----
module lsc_repl #(
  parameter int WAYS   = 4,
  parameter int RANK_W = 2
) (
  input  logic [WAYS-1:0][lsc_pkg::TAG_W-1:0] tags_i,
  input  logic [WAYS-1:0][RANK_W-1:0]         ranks_i,
  input  logic [WAYS-1:0]                     valid_i,
  input  logic [WAYS-1:0]                     in_use_i,
  input  logic [lsc_pkg::TAG_W-1:0]           tag_i,
  output logic [WAYS-1:0][lsc_pkg::TAG_W-1:0] tags_o,
  output logic [WAYS-1:0][RANK_W-1:0]         ranks_o,
  output logic [WAYS-1:0]                     valid_o,
  output lsc_pkg::outcome_t                   outcome_o
);
  import lsc_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  free_way;
  logic [WAY_W-1:0]  vic_way;
  logic              hit_any;
  logic              free_any;
  logic [RANK_W-1:0] ref_rank;

  // Tag match, free way and LRU victim search over the ways in use.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    hit_any  = 1'b0;
    free_any = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && in_use_i[w] && (tags_i[w] == tag_i)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_i[w] && in_use_i[w]) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    // Oldest way wins; a tie goes to the lower way.
    vic_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (in_use_i[w] && (ranks_i[w] > ranks_i[vic_way])) begin
        vic_way = WAY_W'(w);
      end
    end
  end

  // Line update: refresh on a hit, fill a free way, or replace the victim.
  always_comb begin
    tags_o    = tags_i;
    ranks_o   = ranks_i;
    valid_o   = valid_i;
    outcome_o = '0;
    ref_rank  = '0;
    if (hit_any) begin
      outcome_o.hit = 1'b1;
      ref_rank = ranks_i[hit_way];
      for (int w = 0; w < WAYS; w++) begin
        if (in_use_i[w] && valid_i[w] && (ranks_i[w] < ref_rank)) begin
          ranks_o[w] = ranks_i[w] + 1'b1;
        end
      end
      ranks_o[hit_way] = '0;
    end else if (free_any) begin
      outcome_o.miss = 1'b1;
      for (int w = 0; w < WAYS; w++) begin
        if (in_use_i[w] && valid_i[w] && (ranks_i[w] < RANK_MAX)) begin
          ranks_o[w] = ranks_i[w] + 1'b1;
        end
      end
      valid_o[free_way] = 1'b1;
      tags_o[free_way]  = tag_i;
      ranks_o[free_way] = '0;
    end else begin
      outcome_o.miss  = 1'b1;
      outcome_o.evict = 1'b1;
      ref_rank = ranks_i[vic_way];
      for (int w = 0; w < WAYS; w++) begin
        if (in_use_i[w] && valid_i[w] && (ranks_i[w] < ref_rank)) begin
          ranks_o[w] = ranks_i[w] + 1'b1;
        end
      end
      tags_o[vic_way]  = tag_i;
      ranks_o[vic_way] = '0;
    end
  end

endmodule

// ----- rtl/lru_set_assoc_cache_sim.sv -----
// Set-associative cache hit/miss tracker with true LRU replacement.
// A result strobes on done_o after the start beat passes s1_vld_q, then out_vld_q.
// Throughput: one access per cycle; busy is never raised, set by the one
// tag/rank memory port pair and the single-pass lookup between its registers.
// Reset: asynchronous, active low; empties the cache, zeroes the totals and
// restores the default split; no clearing pass is needed after reset.
module lru_set_assoc_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [lsc_pkg::REQ_W-1:0]       req_type_i,
  input  logic [lsc_pkg::ADDR_W-1:0]      address_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            done_o,
  output logic [1:0]                      hits_now_o,
  output logic                            missed_now_o,
  output logic                            evicted_now_o,
  output logic [lsc_pkg::CNT_W-1:0]       total_hits_o,
  output logic [lsc_pkg::CNT_W-1:0]       total_misses_o,
  output logic [lsc_pkg::CNT_W-1:0]       total_evictions_o
);
  import lsc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = MAX_SET_BITS;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
  localparam int SB_RST   = (MAX_SET_BITS < 4) ? MAX_SET_BITS : 4;

  // Configuration, stored already saturated into the meaningful range.
  logic [SB_W-1:0] sb_q;
  logic [BB_W-1:0] bb_q;
  logic [WAYS-1:0] in_use_q;

  // Stage 1: accepted access and the set row read for it.
  logic                           s1_vld_q;
  req_e                           s1_type_q;
  logic [ADDR_W-1:0]              s1_addr_q;
  logic [SET_W-1:0]               s1_set_q;
  logic [WAYS-1:0][TAG_W-1:0]     rd_tags_q;
  logic [WAYS-1:0][RANK_W-1:0]    rd_ranks_q;

  // Last row written, forwarded when the next access hits the same set.
  logic                           byp_vld_q;
  logic [SET_W-1:0]               byp_set_q;
  logic [WAYS-1:0][TAG_W-1:0]     byp_tags_q;
  logic [WAYS-1:0][RANK_W-1:0]    byp_ranks_q;

  // Line storage.
  logic [WAYS-1:0][TAG_W-1:0]     tag_mem  [NUM_SETS];
  logic [WAYS-1:0][RANK_W-1:0]    rank_mem [NUM_SETS];
  logic [WAYS-1:0]                valid_q  [NUM_SETS];

  // Results and totals.
  logic                           out_vld_q;
  logic [1:0]                     hits_now_q;
  logic                           missed_now_q;
  logic                           evicted_now_q;
  logic [CNT_W-1:0]               tot_hits_q;
  logic [CNT_W-1:0]               tot_misses_q;
  logic [CNT_W-1:0]               tot_evict_q;

  logic                           accept;
  logic [ADDR_W-1:0]              addr_sh;
  logic [SET_W-1:0]               set_mask;
  logic [SET_W-1:0]               set_d;
  logic [TAG_SH_W-1:0]            tag_sh;
  logic [ADDR_W-1:0]              tag_full;
  logic [TAG_W-1:0]               tag;
  logic                           use_byp;
  logic [WAYS-1:0][TAG_W-1:0]     row_tags;
  logic [WAYS-1:0][RANK_W-1:0]    row_ranks;
  logic [WAYS-1:0]                row_valid;
  logic [WAYS-1:0][TAG_W-1:0]     new_tags;
  logic [WAYS-1:0][RANK_W-1:0]    new_ranks;
  logic [WAYS-1:0]                new_valid;
  outcome_t                       outcome;
  logic                           do_access;
  logic [1:0]                     hit_inc;
  logic [CNT_W:0]                 hit_sum;
  logic [CNT_W-1:0]               hits_d;
  logic [CNT_W-1:0]               misses_d;
  logic [CNT_W-1:0]               evict_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Configuration writes, saturated on the way in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q     <= SB_W'(SB_RST);
      bb_q     <= BB_W'(4);
      in_use_q <= WAYS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SET_BITS: begin
          if (cfg_data_i[2:0] == 3'd0) begin
            sb_q <= SB_W'(1);
          end else if (int'(cfg_data_i[2:0]) > MAX_SET_BITS) begin
            sb_q <= SB_W'(MAX_SET_BITS);
          end else begin
            sb_q <= SB_W'(cfg_data_i[2:0]);
          end
        end
        CFG_BLOCK_BITS: begin
          if (cfg_data_i == '0) begin
            bb_q <= BB_W'(1);
          end else if (cfg_data_i > BB_W'(32)) begin
            bb_q <= BB_W'(32);
          end else begin
            bb_q <= cfg_data_i;
          end
        end
        CFG_WAYS_USED: begin
          for (int w = 0; w < WAYS; w++) begin
            in_use_q[w] <= (w == 0) || (int'(cfg_data_i[2:0]) > w);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stage 0: set index from the incoming address.
  always_comb begin
    addr_sh = address_i >> bb_q;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(sb_q));
    end
    set_d = addr_sh[SET_W-1:0] & set_mask;
  end

  // Stage 0 to 1 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  // Stage 0 to 1 payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q <= req_e'(req_type_i);
      s1_addr_q <= address_i;
      s1_set_q  <= set_d;
    end
  end

  // Tag and rank memories: read for the new access, write back the updated row.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_tags_q  <= tag_mem[set_d];
      rd_ranks_q <= rank_mem[set_d];
    end
    if (do_access) begin
      tag_mem[s1_set_q]  <= new_tags;
      rank_mem[s1_set_q] <= new_ranks;
    end
  end

  // Stage 1: tag extraction and row selection with forwarding.
  always_comb begin
    tag_sh    = TAG_SH_W'(bb_q) + TAG_SH_W'(sb_q);
    tag_full  = s1_addr_q >> tag_sh;
    tag       = tag_full[TAG_W-1:0];
    use_byp   = byp_vld_q && (byp_set_q == s1_set_q);
    row_tags  = use_byp ? byp_tags_q  : rd_tags_q;
    row_ranks = use_byp ? byp_ranks_q : rd_ranks_q;
    row_valid = valid_q[s1_set_q];
    do_access = s1_vld_q && (s1_type_q != REQ_IFETCH);
  end

  lsc_repl #(
    .WAYS   (WAYS),
    .RANK_W (RANK_W)
  ) u_repl (
    .tags_i    (row_tags),
    .ranks_i   (row_ranks),
    .valid_i   (row_valid),
    .in_use_i  (in_use_q),
    .tag_i     (tag),
    .tags_o    (new_tags),
    .ranks_o   (new_ranks),
    .valid_o   (new_valid),
    .outcome_o (outcome)
  );

  // Saturating totals; a modify adds one guaranteed hit.
  always_comb begin
    hit_inc  = {1'b0, outcome.hit} + {1'b0, (s1_type_q == REQ_MODIFY)};
    hit_sum  = {1'b0, tot_hits_q} + (CNT_W + 1)'(hit_inc);
    hits_d   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    misses_d = tot_misses_q;
    if (outcome.miss && (tot_misses_q != '1)) begin
      misses_d = tot_misses_q + 1'b1;
    end
    evict_d = tot_evict_q;
    if (outcome.evict && (tot_evict_q != '1)) begin
      evict_d = tot_evict_q + 1'b1;
    end
  end

  // Valid bits, forwarding control, results and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
      byp_vld_q     <= 1'b0;
      out_vld_q     <= 1'b0;
      hits_now_q    <= '0;
      missed_now_q  <= 1'b0;
      evicted_now_q <= 1'b0;
      tot_hits_q    <= '0;
      tot_misses_q  <= '0;
      tot_evict_q   <= '0;
    end else begin
      out_vld_q <= s1_vld_q;
      if (do_access) begin
        valid_q[s1_set_q] <= new_valid;
        byp_vld_q         <= 1'b1;
        hits_now_q        <= hit_inc;
        missed_now_q      <= outcome.miss;
        evicted_now_q     <= outcome.evict;
        tot_hits_q        <= hits_d;
        tot_misses_q      <= misses_d;
        tot_evict_q       <= evict_d;
      end else begin
        hits_now_q    <= '0;
        missed_now_q  <= 1'b0;
        evicted_now_q <= 1'b0;
      end
    end
  end

  // Forwarded row payload.
  always_ff @(posedge clk_i) begin
    if (do_access) begin
      byp_set_q   <= s1_set_q;
      byp_tags_q  <= new_tags;
      byp_ranks_q <= new_ranks;
    end
  end

  assign done_o            = out_vld_q;
  assign hits_now_o        = hits_now_q;
  assign missed_now_o      = missed_now_q;
  assign evicted_now_o     = evicted_now_q;
  assign total_hits_o      = tot_hits_q;
  assign total_misses_o    = tot_misses_q;
  assign total_evictions_o = tot_evict_q;

`include "lru_set_assoc_cache_sim_macros.svh"

  // Every accepted beat yields exactly one result via s1_vld_q and out_vld_q.
  `LSC_ASSERT_NEXT(a_done_follows_start, start && !busy, ##1 done_o, "result missing after start")

  // A missed result never reports two hits, and only a miss can evict.
  `LSC_ASSERT_IMPL(a_outcome_consistent, done_o && (missed_now_o || evicted_now_o),
                   missed_now_o && (hits_now_o != 2'd2), "inconsistent outcome flags")

  // The miss total follows the miss flag until it saturates.
  `LSC_ASSERT_IMPL(a_miss_total_step, done_o && missed_now_o && ($past(total_misses_o) != '1),
                   total_misses_o == $past(total_misses_o) + 1'b1, "miss total did not advance")

endmodule
